// ===== rtl/fwap_pkg.sv =====
// Shared types and constants for the all-pairs shortest-path core.
package fwap_pkg;

    // Widest row index and distance the core can be built with
    localparam int ROW_MAX_BITS  = 6;
    localparam int DIST_MAX_BITS = 32;
    localparam int OUT_BITS      = 24;

    // Command codes on the input channel
    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_RUN   = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    // Relaxation token passed from cell to cell along the chain
    typedef struct packed {
        logic                     valid;
        logic [ROW_MAX_BITS-1:0]  row;
        logic [DIST_MAX_BITS-1:0] dak;
    } t_token;

endpackage

// ===== rtl/floyd_warshall_all_pairs_core.sv =====
// Clear, write and read act when they are taken; a read result is registered.
// A run handles the n pivots in turn: per pivot one row token enters the
// column-cell chain each cycle, then the chain drains.
// Throughput: one command per cycle when idle and no read result is held back
// on the output; no command and no configuration write is taken during a run.
// Reset (synchronous, active low) sets the matrix to zero diagonal, infinity
// elsewhere, vertex count to 16 and the output channel empty.
module floyd_warshall_all_pairs_core import fwap_pkg::*; #(
    parameter int MAX_VERTICES = 16,
    parameter int DIST_BITS    = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_command,
    input  logic [3:0]          i_src_vertex,
    input  logic [3:0]          i_dst_vertex,
    input  logic [15:0]         i_edge_weight,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [OUT_BITS-1:0] o_distance,
    output logic                o_reachable,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [4:0]          i_cfg_data
);
    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam logic [DIST_BITS-1:0] INF = {DIST_BITS{1'b1}};

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN
    } t_state;

    t_state               r_state;
    logic [VW-1:0]        r_k;
    logic [VW-1:0]        r_a;
    logic [4:0]           r_vertex_count;
    logic                 r_out_valid;
    logic [OUT_BITS-1:0]  r_distance;
    logic                 r_reachable;
    t_token               r_tok;

    t_token               w_tok [MAX_VERTICES+1];
    logic [DIST_BITS-1:0] w_col [MAX_VERTICES][MAX_VERTICES];
    logic [NW-1:0]        w_n;
    logic                 w_accept;
    logic                 w_inside;
    logic [VW-1:0]        w_src;
    logic [VW-1:0]        w_dst;
    logic [DIST_BITS-1:0] w_wdata;
    logic [DIST_BITS-1:0] w_entry;
    logic                 w_reach;
    logic                 w_busy;
    logic                 w_clear;
    logic                 w_write;
    logic                 w_a_last;
    logic                 w_k_last;

    // Configuration register, held off while a run is in progress
    assign o_cfg_ready = (r_state == S_IDLE);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= 5'd16;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_vertex_count <= i_cfg_data;
        end
    end

    // Effective vertex count, decode of the incoming command
    always_comb begin
        if (32'(r_vertex_count) > MAX_VERTICES) begin
            w_n = NW'(MAX_VERTICES);
        end else begin
            w_n = NW'(r_vertex_count);
        end
        w_accept = i_in_valid && o_in_ready;
        w_inside = (32'(i_src_vertex) < MAX_VERTICES) && (32'(i_dst_vertex) < MAX_VERTICES);
        w_src    = VW'(i_src_vertex);
        w_dst    = VW'(i_dst_vertex);
        if (32'(i_edge_weight) >= 32'(INF)) begin
            w_wdata = INF;
        end else begin
            w_wdata = DIST_BITS'(i_edge_weight);
        end
        w_entry  = w_col[w_dst][w_src];
        w_reach  = w_inside && (w_entry != INF);
        w_clear  = w_accept && (i_command == CMD_CLEAR);
        w_write  = w_accept && (i_command == CMD_WRITE) && w_inside;
        w_a_last = (NW'(r_a) + NW'(1)) == w_n;
        w_k_last = (NW'(r_k) + NW'(1)) == w_n;
    end

    // Any token still in flight
    always_comb begin
        w_busy = r_tok.valid;
        for (int b = 1; b <= MAX_VERTICES; b++) begin
            w_busy = w_busy | w_tok[b].valid;
        end
    end

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);

    // Chain of column cells
    assign w_tok[0] = r_tok;
    for (genvar b = 0; b < MAX_VERTICES; b++) begin : g_cell
        fwap_cell #(
            .MAX_VERTICES (MAX_VERTICES),
            .DIST_BITS    (DIST_BITS),
            .CELL_IDX     (b)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_clear   (w_clear),
            .i_wr_en   (w_write && (32'(w_dst) == b)),
            .i_wr_row  (w_src),
            .i_wr_data (w_wdata),
            .i_pivot   (r_k),
            .i_active  (NW'(b) < w_n),
            .i_tok     (w_tok[b]),
            .o_tok     (w_tok[b+1]),
            .o_col     (w_col[b])
        );
    end

    // Launch register: one row token per cycle during a pivot pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok.valid <= (r_state == S_RUN);
            r_tok.row   <= ROW_MAX_BITS'(r_a);
            r_tok.dak   <= DIST_MAX_BITS'(w_col[r_k][r_a]);
        end
    end

    // Sequencer and read result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_a         <= '0;
            r_out_valid <= 1'b0;
            r_distance  <= '0;
            r_reachable <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept && i_command == CMD_READ) begin
                        r_out_valid <= 1'b1;
                        r_distance  <= w_reach ? OUT_BITS'(w_entry) : '0;
                        r_reachable <= w_reach;
                    end
                    if (w_accept && i_command == CMD_RUN && w_n != '0) begin
                        r_state <= S_RUN;
                        r_k     <= '0;
                        r_a     <= '0;
                    end
                end
                S_RUN: begin
                    if (w_a_last) begin
                        r_a     <= '0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_a <= r_a + VW'(1);
                    end
                end
                S_DRAIN: begin
                    if (!w_busy) begin
                        if (w_k_last) begin
                            r_k     <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + VW'(1);
                            r_state <= S_RUN;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_distance  = r_distance;
    assign o_reachable = r_reachable;

`ifndef ASSERT_OFF
    // No command is taken while a run is in progress
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready)
        else $error("command accepted during run");

    // An accepted read produces a pending result
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_command == CMD_READ) |=> o_out_valid)
        else $error("read transfer gave no result");

    // No tokens are launched while the chain drains
    a_drain_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |=> !r_tok.valid)
        else $error("token launched during drain");

    // A run returns to idle once the chain is empty after the last pivot
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN && w_k_last && !w_busy) |=> (r_state == S_IDLE))
        else $error("run did not finish after last pivot");
`endif

endmodule

// ===== rtl/fwap_cell.sv =====
// One column cell of the distance matrix: stores a column and relaxes it.
module fwap_cell import fwap_pkg::*; #(
    parameter int MAX_VERTICES = 16,
    parameter int DIST_BITS    = 24,
    parameter int CELL_IDX     = 0
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_clear,
    input  logic                                   i_wr_en,
    input  logic [((MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1)-1:0] i_wr_row,
    input  logic [DIST_BITS-1:0]                   i_wr_data,
    input  logic [((MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1)-1:0] i_pivot,
    input  logic                                   i_active,
    input  t_token                                 i_tok,
    output t_token                                 o_tok,
    output logic [DIST_BITS-1:0]                   o_col [MAX_VERTICES]
);
    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam logic [DIST_BITS-1:0] INF = {DIST_BITS{1'b1}};

    logic [DIST_BITS-1:0] r_col [MAX_VERTICES];
    t_token               r_tok;
    logic [VW-1:0]        w_row;
    logic [DIST_BITS-1:0] w_dak;
    logic [DIST_BITS-1:0] w_pk;
    logic [DIST_BITS-1:0] w_cur;
    logic [DIST_BITS:0]   w_sum;
    logic [DIST_BITS-1:0] w_via;
    logic                 w_upd;

    // Saturating add of d[a][k] + d[k][b], compare with d[a][b]
    always_comb begin
        w_row = i_tok.row[VW-1:0];
        w_dak = i_tok.dak[DIST_BITS-1:0];
        w_pk  = r_col[i_pivot];
        w_cur = r_col[w_row];
        w_sum = {1'b0, w_dak} + {1'b0, w_pk};
        if (w_dak == INF || w_pk == INF || w_sum >= {1'b0, INF}) begin
            w_via = INF;
        end else begin
            w_via = w_sum[DIST_BITS-1:0];
        end
        w_upd = i_tok.valid && i_active && (w_via < w_cur);
    end

    // Column storage: clear, edge write or relaxation update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            for (int i = 0; i < MAX_VERTICES; i++) begin
                r_col[i] <= (i == CELL_IDX) ? '0 : INF;
            end
        end else if (i_wr_en) begin
            r_col[i_wr_row] <= i_wr_data;
        end else if (w_upd) begin
            r_col[w_row] <= w_via;
        end
    end

    // Hand the token to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= i_tok;
        end
    end

    assign o_tok = r_tok;
    assign o_col = r_col;

endmodule
